[src/pidc_pkg.sv]
package pidc_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned ERR_W   = DATA_W + 1;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned DIV_W   = ERR_W + 1;
  localparam int unsigned MUL_A_W = DIV_W;
  localparam int unsigned MUL_B_W = ACC_W / 2 + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P  = 3'd0,
    CFG_GAIN_I  = 3'd1,
    CFG_GAIN_D  = 3'd2,
    CFG_TARGET  = 3'd3,
    CFG_OUT_MAX = 3'd4,
    CFG_OUT_MIN = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_MAX  = 2'd1,
    CLAMP_MIN  = 2'd2
  } clamp_t;

  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = 16'sh8000;
  localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

[src/pid_controller_clamped_core.sv]
// Channel | Direction | Payload
// in_     | sink      | tdata: measured [15:0], elapsed_ms [31:16]
// out_    | source    | tdata: drive [15:0]; tuser: clamp_state [1:0]
// cfg_    | write     | cfg_index selects gain_p..out_min, cfg_wdata is the value
//
// Most of a transaction's work, from acceptance to a valid result, is the
// 18-step restoring divider for the derivative, skipped when elapsed_ms is zero.
// One shared 18x25 signed multiplier forms every product, one per cycle.
// rst_n is synchronous: gains and target go to zero, limits to full range,
// the integral and the stored error to zero. A stalled result waits in the
// output register while the next transaction is accepted and worked on.
module pid_controller_clamped_core #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // measured [15:0], elapsed_ms [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // drive [15:0]
  output logic [1:0]  out_tuser,  // clamp_state [1:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned DW   = pidc_pkg::DATA_W;
  localparam int unsigned EW   = pidc_pkg::ERR_W;
  localparam int unsigned AW   = pidc_pkg::ACC_W;
  localparam int unsigned DVW  = pidc_pkg::DIV_W;
  localparam int unsigned MAW  = pidc_pkg::MUL_A_W;
  localparam int unsigned MBW  = pidc_pkg::MUL_B_W;
  localparam int unsigned MPW  = pidc_pkg::MUL_P_W;
  localparam int unsigned SW   = pidc_pkg::SUM_W;
  localparam int unsigned HALF = AW / 2;
  localparam int unsigned CNT_W = $clog2(DVW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INT_MUL, S_INT_ADD, S_DIV, S_DSGN,
    S_MP, S_MIL, S_MIH, S_MD, S_ACC,
    S_SHIFT, S_SIGN, S_CLAMP
  } state_t;

  state_t state_r;

  logic signed [DW-1:0] gain_p_r, gain_i_r, gain_d_r, target_r, out_max_r, out_min_r;
  logic signed [EW-1:0] err_r, last_err_r;
  logic [DW-1:0]        dt_r;
  logic signed [AW-1:0] integ_r;
  logic signed [DVW-1:0] deriv_r;
  logic [DVW-1:0]       quo_r;
  logic [DW-1:0]        rem_r;
  logic                 div_neg_r;
  logic [CNT_W-1:0]     cnt_r;
  logic signed [MPW-1:0] prod_r;
  logic signed [SW-1:0] sum_r;
  logic [SW-1:0]        mag_r;
  logic                 neg_r;
  logic signed [SW-1:0] res_r;
  logic                 out_tvalid_r;
  logic [DW-1:0]        drive_r;
  pidc_pkg::clamp_t     clamp_r;

  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [MPW-1:0] mul_p;
  logic signed [DVW-1:0] diff_c;
  logic [DVW-1:0]        diff_mag_c;
  logic signed [AW:0]    integ_sum_c;
  logic signed [AW-1:0]  integ_sat_c;
  logic [DW:0]           rem_sh_c;
  logic [DW:0]           rem_sub_c;
  logic                  div_ge_c;
  logic signed [SW-1:0]  prod_ext_c;
  logic signed [SW-1:0]  acc_term_c;
  logic [SW-1:0]         abs_c;
  logic signed [SW-1:0]  max_ext_c, min_ext_c;
  logic                  out_free;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_INT_MUL: begin
        mul_a = MAW'($signed({1'b0, dt_r}));
        mul_b = MBW'(err_r);
      end
      S_MP: begin
        mul_a = MAW'(gain_p_r);
        mul_b = MBW'(err_r);
      end
      S_MIL: begin
        mul_a = MAW'(gain_i_r);
        mul_b = $signed({1'b0, integ_r[HALF-1:0]});
      end
      S_MIH: begin
        mul_a = MAW'(gain_i_r);
        mul_b = MBW'($signed(integ_r[AW-1:HALF]));
      end
      S_MD: begin
        mul_a = MAW'(gain_d_r);
        mul_b = MBW'(deriv_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    diff_c     = DVW'(err_r) - DVW'(last_err_r);
    diff_mag_c = diff_c[DVW-1] ? DVW'(-diff_c) : DVW'(diff_c);

    integ_sum_c = (AW+1)'(integ_r) + (AW+1)'(prod_r);
    if (integ_sum_c[AW] != integ_sum_c[AW-1]) begin
      integ_sat_c = integ_sum_c[AW] ? pidc_pkg::ACC_MIN : pidc_pkg::ACC_MAX;
    end else begin
      integ_sat_c = integ_sum_c[AW-1:0];
    end

    rem_sh_c  = {rem_r, quo_r[DVW-1]};
    rem_sub_c = rem_sh_c - {1'b0, dt_r};
    div_ge_c  = rem_sh_c >= {1'b0, dt_r};

    prod_ext_c = SW'(prod_r);
    // The upper integral half carries a weight of 2^HALF.
    acc_term_c = (state_r == S_MD) ? (prod_ext_c <<< HALF) : prod_ext_c;

    abs_c = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);

    max_ext_c = SW'(out_max_r);
    min_ext_c = SW'(out_min_r);
  end

  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = drive_r;
  assign out_tuser  = clamp_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      target_r     <= '0;
      out_max_r    <= pidc_pkg::OUT_MAX_RST;
      out_min_r    <= pidc_pkg::OUT_MIN_RST;
      integ_r      <= '0;
      last_err_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pidc_pkg::CFG_GAIN_P:  gain_p_r  <= cfg_wdata;
          pidc_pkg::CFG_GAIN_I:  gain_i_r  <= cfg_wdata;
          pidc_pkg::CFG_GAIN_D:  gain_d_r  <= cfg_wdata;
          pidc_pkg::CFG_TARGET:  target_r  <= cfg_wdata;
          pidc_pkg::CFG_OUT_MAX: out_max_r <= cfg_wdata;
          pidc_pkg::CFG_OUT_MIN: out_min_r <= cfg_wdata;
          default: ;
        endcase
      end

      // In S_CLAMP the result register handles its own valid flag.
      if (out_tvalid_r && out_tready && (state_r != S_CLAMP)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            err_r   <= EW'(target_r) - EW'($signed(in_tdata[DW-1:0]));
            dt_r    <= in_tdata[2*DW-1:DW];
            state_r <= S_INT_MUL;
          end
        end
        S_INT_MUL: begin
          quo_r      <= diff_mag_c;
          div_neg_r  <= diff_c[DVW-1];
          rem_r      <= '0;
          cnt_r      <= CNT_LAST;
          last_err_r <= err_r;
          state_r    <= S_INT_ADD;
        end
        S_INT_ADD: begin
          if (dt_r != '0) begin
            integ_r <= integ_sat_c;
            state_r <= S_DIV;
          end else begin
            deriv_r <= '0;
            state_r <= S_MP;
          end
        end
        S_DIV: begin
          rem_r <= div_ge_c ? rem_sub_c[DW-1:0] : rem_sh_c[DW-1:0];
          quo_r <= {quo_r[DVW-2:0], div_ge_c};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_DSGN;
          end
        end
        S_DSGN: begin
          deriv_r <= div_neg_r ? DVW'(-$signed(quo_r)) : $signed(quo_r);
          state_r <= S_MP;
        end
        S_MP: begin
          sum_r   <= '0;
          state_r <= S_MIL;
        end
        S_MIL: begin
          sum_r   <= sum_r + acc_term_c;
          state_r <= S_MIH;
        end
        S_MIH: begin
          sum_r   <= sum_r + acc_term_c;
          state_r <= S_MD;
        end
        S_MD: begin
          sum_r   <= sum_r + acc_term_c;
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_r + acc_term_c;
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          // Shift the magnitude so a negative sum rounds toward zero.
          mag_r   <= abs_c >> FRAC_BITS;
          neg_r   <= sum_r[SW-1];
          state_r <= S_SIGN;
        end
        S_SIGN: begin
          res_r   <= neg_r ? SW'(-$signed(mag_r)) : $signed(mag_r);
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            // The upper limit is tested first, so when limits cross it wins for any result above it.
            if (res_r > max_ext_c) begin
              drive_r <= out_max_r;
              clamp_r <= pidc_pkg::CLAMP_MAX;
            end else if (res_r < min_ext_c) begin
              drive_r <= out_min_r;
              clamp_r <= pidc_pkg::CLAMP_MIN;
            end else begin
              drive_r <= res_r[DW-1:0];
              clamp_r <= pidc_pkg::CLAMP_NONE;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
